// ===== rtl/pulse_tachometer_smoother_macros.svh =====
// Assertion macros shared by the tachometer smoother RTL.
// Clocked on clk_i and disabled while rst_ni is low; no other dependencies.
`ifndef PULSE_TACHOMETER_SMOOTHER_MACROS_SVH
`define PULSE_TACHOMETER_SMOOTHER_MACROS_SVH

// same-cycle implication
`define PTS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pts_pkg.sv =====
// Package for the tachometer smoother: constants, sequencer states, control structs.
// No dependencies.
package pts_pkg;

  localparam int unsigned DIV_W          = 16;  // divider operand width
  localparam int unsigned CNT_W          = 5;   // holds a step count up to DIV_W
  localparam int unsigned RPM_W          = 16;
  localparam int unsigned FRAC_BITS_DEF  = 10;
  localparam int unsigned REPORT_SHIFT   = 5;

  localparam logic [RPM_W-1:0] RPM_NUMERATOR = 16'd60000;
  localparam logic [RPM_W-1:0] REPORT_LIMIT  = 16'd8160;
  localparam logic [7:0]       REPORT_SAT    = 8'hFF;
  localparam logic [15:0]      REACTION_RST  = 16'd200;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INTV,
    ST_CMP,
    ST_IDIV_GO,
    ST_IDIV_WAIT,
    ST_WDIV_GO,
    ST_WDIV_WAIT,
    ST_MUL1,
    ST_MUL2,
    ST_MACW,
    ST_RESULT
  } seq_state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] rem_init;   // starting partial remainder, must be below divisor
    logic [DIV_W-1:0] dividend;   // bits shifted in from the top
    logic [DIV_W-1:0] divisor;
    logic [CNT_W-1:0] steps;      // quotient bits to produce
  } div_req_t;

  typedef struct packed {
    logic en;     // register a product this cycle
    logic clear;  // this product starts a new sum
  } mac_ctl_t;

endpackage

// ===== rtl/pts_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on pts_pkg.
`include "pulse_tachometer_smoother_macros.svh"

module pts_div
  import pts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0] dsr_q, dsr_d;
  logic [DIV_W-1:0] quo_q, quo_d;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           fits;

  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  `PTS_ASSERT_NOW(a_div_no_restart, req_i.start, !busy_q, "divider restarted while busy")
  `PTS_ASSERT_NOW(a_div_cnt_live, busy_q, cnt_q != '0, "divider busy with zero steps left")

endmodule

// ===== rtl/pts_mac.sv =====
// Registered multiply-accumulate used for the weighted blend.
// Depends on pts_pkg.
module pts_mac
  import pts_pkg::*;
#(
  parameter int unsigned AW = FRAC_BITS_DEF + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mac_ctl_t              ctl_i,
  input  logic [AW-1:0]         a_i,
  input  logic [RPM_W-1:0]      b_i,
  output logic [AW+RPM_W-1:0]   acc_o
);

  localparam int unsigned PW = AW + RPM_W;

  logic          vld_q, clr_q;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] acc_q, acc_d;

  // product is registered first and summed into the accumulator in the next cycle
  always_comb begin
    acc_d = acc_q;
    if (vld_q) begin
      acc_d = (clr_q ? '0 : acc_q) + prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      vld_q <= ctl_i.en;
      clr_q <= ctl_i.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q <= PW'(a_i) * PW'(b_i);
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/pulse_tachometer_smoother.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  pulse_time_ms
// m_axis    out  m_axis_tvalid/m_axis_tready  instant_rpm, smoothed_rpm, report_byte
// cfg       in   cfg_valid_i/cfg_ready_o      reaction_time_ms
//
// A blending pulse word goes through the shared serial divider, one quotient bit per
// cycle, for the instant RPM and then for the weight (only the weight when the interval
// is above 60000 ms); a replaced average takes only the instant-RPM pass, none when the
// interval is above 60000 ms. s_axis_tready is high only while idle.
// The result register lets the next pulse enter while a result waits; a stalled
// m_axis holds the sequencer in its final step. cfg is always ready.
// Reset (rst_ni, async low): last pulse time and average zero, reaction time 200 ms.
// Depends on pts_pkg, pts_div, pts_mac.
`include "pulse_tachometer_smoother_macros.svh"

module pulse_tachometer_smoother
  import pts_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] pulse_time_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] instant_rpm, [31:16] smoothed_rpm,
                                      // [39:32] report_byte
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // [15:0] reaction_time_ms
);

  localparam int unsigned AW = FRAC_BITS + 1;
  localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  seq_state_e state_q, state_d;

  logic [15:0]          react_q, react_d;
  logic [31:0]          now_q, now_d;
  logic [31:0]          last_q, last_d;
  logic [31:0]          intv_q, intv_d;
  logic                 replace_q, replace_d;
  logic [RPM_W-1:0]     inst_q, inst_d;
  logic [FRAC_BITS-1:0] w_q, w_d;
  logic [RPM_W-1:0]     avg_q, avg_d;
  logic                 out_vld_q, out_vld_d;
  logic [39:0]          out_q, out_d;

  div_req_t             div_req;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  mac_ctl_t             mac_ctl;
  logic [AW-1:0]        mac_a;
  logic [AW+RPM_W-1:0]  mac_acc;

  logic [31:0]          diff;
  logic                 big, reach, out_free;
  logic [RPM_W-1:0]     blend, new_avg;
  logic [7:0]           report;

  assign diff     = now_q - last_q;
  assign big      = intv_q > {16'd0, RPM_NUMERATOR};
  assign reach    = intv_q >= {16'd0, react_q};
  assign out_free = !out_vld_q || m_axis_tready;
  assign blend    = mac_acc[FRAC_BITS +: RPM_W];
  assign new_avg  = replace_q ? inst_q : blend;
  assign report   = (new_avg > REPORT_LIMIT) ? REPORT_SAT : 8'(new_avg >> REPORT_SHIFT);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (s_axis_tvalid) state_d = ST_INTV;
      ST_INTV:      state_d = ST_CMP;
      ST_CMP: begin
        if (!big)       state_d = ST_IDIV_GO;
        else if (reach) state_d = ST_RESULT;
        else            state_d = ST_WDIV_GO;
      end
      ST_IDIV_GO:   state_d = ST_IDIV_WAIT;
      ST_IDIV_WAIT: if (div_done) state_d = replace_q ? ST_RESULT : ST_WDIV_GO;
      ST_WDIV_GO:   state_d = ST_WDIV_WAIT;
      ST_WDIV_WAIT: if (div_done) state_d = ST_MUL1;
      ST_MUL1:      state_d = ST_MUL2;
      ST_MUL2:      state_d = ST_MACW;
      ST_MACW:      state_d = ST_RESULT;
      ST_RESULT:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    react_d   = react_q;
    now_d     = now_q;
    last_d    = last_q;
    intv_d    = intv_q;
    replace_d = replace_q;
    inst_d    = inst_q;
    w_d       = w_q;
    avg_d     = avg_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    div_req   = '0;
    mac_ctl   = '0;
    mac_a     = {1'b0, w_q};
    if (cfg_valid_i) begin
      react_d = cfg_data_i;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) now_d = s_axis_tdata;
      end
      ST_INTV: begin
        intv_d = (diff == '0) ? 32'd1 : diff;
        last_d = now_q;
      end
      ST_CMP: begin
        replace_d = reach;
        if (big) inst_d = '0;
      end
      ST_IDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.dividend = RPM_NUMERATOR;
        div_req.divisor  = intv_q[DIV_W-1:0];
        div_req.steps    = CNT_W'(DIV_W);
      end
      ST_IDIV_WAIT: begin
        if (div_done) inst_d = div_quo;
      end
      ST_WDIV_GO: begin
        // interval < reaction here, so it is a valid starting remainder
        div_req.start    = 1'b1;
        div_req.rem_init = intv_q[DIV_W-1:0];
        div_req.dividend = '0;
        div_req.divisor  = react_q;
        div_req.steps    = CNT_W'(FRAC_BITS);
      end
      ST_WDIV_WAIT: begin
        if (div_done) w_d = div_quo[FRAC_BITS-1:0];
      end
      ST_MUL1: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = {1'b0, w_q};
      end
      ST_MUL2: begin
        mac_ctl.en = 1'b1;
        mac_a      = ONE - {1'b0, w_q};
      end
      ST_MACW: ;
      ST_RESULT: begin
        if (out_free) begin
          avg_d     = new_avg;
          out_d     = {report, new_avg, inst_q};
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      react_q   <= REACTION_RST;
      last_q    <= '0;
      avg_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      react_q   <= react_d;
      last_q    <= last_d;
      avg_q     <= avg_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    intv_q    <= intv_d;
    replace_q <= replace_d;
    inst_q    <= inst_d;
    w_q       <= w_d;
    out_q     <= out_d;
  end

  pts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  pts_mac #(
    .AW (AW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    ((state_q == ST_MUL1) ? inst_q : avg_q),
    .acc_o  (mac_acc)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  // a blend never rises above both of its inputs; a new result word comes only from the result step
  `PTS_ASSERT_NOW(a_blend_bounded, (state_q == ST_RESULT) && !replace_q,
                  (blend <= inst_q) || (blend <= avg_q), "blend above both inputs")
  `PTS_ASSERT_NEXT(a_result_from_seq, !out_vld_q || m_axis_tready,
                   !out_vld_q || $past(state_q == ST_RESULT), "result word without sequencer")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for pulse_tachometer_smoother: a directed table, then random pulse
// trains under several reaction times, each word checked against typed or predicted values.
// Depends on pts_pkg and the pulse_tachometer_smoother RTL.
`timescale 1ns / 1ps

module testbench;
  import pts_pkg::*;

  localparam int unsigned FRAC       = FRAC_BITS_DEF;
  localparam int unsigned PHASE_LEN  = 250;
  localparam int unsigned NUM_PHASES = 7;
  localparam int unsigned NUM_ROWS   = 21;

  typedef enum logic {ROW_PULSE, ROW_CFG} row_kind_e;

  // field order matches m_axis_tdata, lowest bits last
  typedef struct packed {
    logic [7:0]  report;
    logic [15:0] smoothed;
    logic [15:0] instant;
  } rpm_word_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;    // pulse time, or reaction time for a config row
    logic        known;    // expected word typed in below
    rpm_word_t   word;
  } pulse_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] pulse_time_ms
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [15:0] instant_rpm, [31:16] smoothed_rpm, [39:32] report_byte
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;     // [15:0] reaction_time_ms

  pulse_tachometer_smoother #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // predictor state
  logic [31:0] last_pulse_q;
  logic [15:0] avg_rpm_q;
  logic [15:0] reaction_q;

  rpm_word_t   rpm_expected[$];
  pulse_row_t  plan [NUM_ROWS];
  bit          idle_on;
  int unsigned bad_words;
  int unsigned pulses_sent;
  int unsigned words_seen;
  int unsigned replaced_cnt;
  int unsigned blended_cnt;
  int unsigned saturated_cnt;
  int unsigned settings_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic rpm_word_t predict_rpm(input logic [31:0] now);
    logic [31:0] gap_ms;
    logic [31:0] inst;
    logic [63:0] weight;
    logic [63:0] mix;
    rpm_word_t   res;
    gap_ms = now - last_pulse_q;
    if (gap_ms == 32'd0) gap_ms = 32'd1;
    inst = 32'(RPM_NUMERATOR) / gap_ms;
    if (gap_ms >= 32'(reaction_q)) begin
      avg_rpm_q = inst[15:0];
      replaced_cnt++;
    end else begin
      weight = (64'(gap_ms) << FRAC) / 64'(reaction_q);
      mix = weight * 64'(inst) + ((64'd1 << FRAC) - weight) * 64'(avg_rpm_q);
      avg_rpm_q = 16'(mix >> FRAC);
      blended_cnt++;
    end
    last_pulse_q = now;
    res.instant  = inst[15:0];
    res.smoothed = avg_rpm_q;
    if (avg_rpm_q > REPORT_LIMIT) begin
      res.report = REPORT_SAT;
      saturated_cnt++;
    end else begin
      res.report = 8'(avg_rpm_q >> REPORT_SHIFT);
    end
    return res;
  endfunction

  task automatic check_rpm_word(input logic [39:0] word);
    rpm_word_t want;
    words_seen++;
    if (rpm_expected.size() == 0) begin
      $error("result word %h with nothing pending", word);
      bad_words++;
      return;
    end
    want = rpm_expected.pop_front();
    if (word[15:0] !== want.instant) begin
      $error("instant_rpm: expected %0d, got %0d", want.instant, word[15:0]);
      bad_words++;
    end
    if (word[31:16] !== want.smoothed) begin
      $error("smoothed_rpm: expected %0d, got %0d", want.smoothed, word[31:16]);
      bad_words++;
    end
    if (word[39:32] !== want.report) begin
      $error("report_byte: expected %0d, got %0d", want.report, word[39:32]);
      bad_words++;
    end
  endtask

  // one pulse word; a typed expectation replaces the predicted one, state advances either way
  task automatic send_pulse(input logic [31:0] stamp, input logic known, input rpm_word_t typed);
    int unsigned gap;
    rpm_word_t   pred;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= stamp;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_rpm(stamp);
    rpm_expected.push_back(known ? typed : pred);
    pulses_sent++;
  endtask

  // reaction time may only change with the block idle
  task automatic write_reaction(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (rpm_expected.size() != 0) @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reaction_q = value;
    settings_cnt++;
  endtask

  // result side: random stalls before each word while idle_on is set
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_rpm_word(m_axis_tdata);
    end
  end

  initial begin
    int unsigned   i;
    int unsigned   p;
    int unsigned   n;
    int unsigned   pick;
    logic [31:0]   stamp;
    logic [15:0]   react;
    logic [15:0]   react_set [NUM_PHASES];
    rpm_word_t     none;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    last_pulse_q  = '0;
    avg_rpm_q     = '0;
    reaction_q    = REACTION_RST;
    bad_words     = 0;
    pulses_sent   = 0;
    words_seen    = 0;
    replaced_cnt  = 0;
    blended_cnt   = 0;
    saturated_cnt = 0;
    settings_cnt  = 1;
    idle_on       = 1'b1;
    none          = '0;

    plan = '{
      '{ROW_PULSE, 32'd1000,       1'b1, '{8'd1,   16'd60,    16'd60}},    // from reset state
      '{ROW_PULSE, 32'd1000,       1'b0, none},                           // repeated stamp
      '{ROW_PULSE, 32'd1199,       1'b0, none},                           // just under window
      '{ROW_PULSE, 32'd1399,       1'b1, '{8'd9,   16'd300,   16'd300}},   // exactly the window
      '{ROW_PULSE, 32'hFFFF_FF00,  1'b1, '{8'd0,   16'd0,     16'd0}},
      '{ROW_PULSE, 32'h0000_0000,  1'b1, '{8'd7,   16'd234,   16'd234}},   // timer wrap
      '{ROW_PULSE, 32'hFFFF_FFFF,  1'b1, '{8'd0,   16'd0,     16'd0}},     // longest interval
      '{ROW_PULSE, 32'hFFFF_FFFF,  1'b0, none},
      '{ROW_CFG,   32'd0,          1'b0, none},                           // zero reaction time
      '{ROW_PULSE, 32'hFFFF_FFFF,  1'b1, '{8'd255, 16'd60000, 16'd60000}},
      '{ROW_PULSE, 32'd6,          1'b1, '{8'd255, 16'd8571,  16'd8571}},  // wrap, saturates
      '{ROW_PULSE, 32'd14,         1'b1, '{8'd234, 16'd7500,  16'd7500}},
      '{ROW_CFG,   32'd65535,      1'b0, none},
      '{ROW_PULSE, 32'd14,         1'b0, none},                           // zero weight
      '{ROW_PULSE, 32'd65548,      1'b0, none},                           // largest weight
      '{ROW_PULSE, 32'd131083,     1'b1, '{8'd0,   16'd0,     16'd0}},
      '{ROW_CFG,   32'd1,          1'b0, none},
      '{ROW_PULSE, 32'd131083,     1'b1, '{8'd255, 16'd60000, 16'd60000}},
      '{ROW_PULSE, 32'd131085,     1'b1, '{8'd255, 16'd30000, 16'd30000}},
      '{ROW_PULSE, 32'd191085,     1'b1, '{8'd0,   16'd1,     16'd1}},
      '{ROW_CFG,   32'd200,        1'b0, none}
    };

    react_set[0] = REACTION_RST;
    react_set[1] = 16'd1;
    react_set[2] = 16'd65535;
    react_set[3] = 16'd0;
    react_set[4] = 16'($urandom_range(2, 64));
    react_set[5] = 16'($urandom_range(100, 3000));
    react_set[6] = 16'($urandom_range(1, 65535));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NUM_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reaction(plan[i].value[15:0]);
      end else begin
        send_pulse(plan[i].value, plan[i].known, plan[i].word);
      end
    end

    stamp = plan[NUM_ROWS-2].value;
    for (p = 0; p < NUM_PHASES; p++) begin
      react = react_set[p];
      write_reaction(react);
      idle_on = (p % 3) != 2;
      for (n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       stamp = stamp;                                  // repeat
          1:       stamp = $urandom;                               // arbitrary jump
          2:       stamp = stamp + 32'(react);                     // at the window
          3:       stamp = stamp + 32'(react) - 32'd1;             // just inside it
          4:       stamp = stamp - 32'($urandom_range(1, 1000));   // backwards, wraps
          default: stamp = stamp + $urandom_range(1, (react < 16'd8) ? 16 :
                                                   32'(react) + 32'(react) / 4);
        endcase
        send_pulse(stamp, 1'b0, none);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (rpm_expected.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("covered %0d pulse words under %0d reaction settings, %0d words checked",
             pulses_sent, settings_cnt, words_seen);
    $display("  %0d averages replaced, %0d blended, %0d saturated reports",
             replaced_cnt, blended_cnt, saturated_cnt);
    if (bad_words == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
